### rtl/core/hst_pkg.sv
package hst_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // fixed payload widths
    localparam int SLOT_FIELD_W = 10;
    localparam int GEN_FIELD_W  = 16;
    localparam int LIVE_FIELD_W = 11;

endpackage

### rtl/core/hst_gen_store.sv
// per-slot generation and in-use bit, one write and one registered read port
module hst_gen_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/hst_free_stack.sv
// lifo storage of freed slot numbers, one push and one registered pop read
module hst_free_stack #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ADDR_W-1:0] wr_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;

    // push
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered top-of-stack read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/generational_handle_slot_table.sv
// Generational handle table: allocate hands out a slot (most recently freed first, else the
// next never-used slot) with its current generation, release validates the handle, bumps the
// generation and frees the slot, check reports whether a handle is still live. One command is
// handled at a time: allocate from the free stack reads the stack, then the popped slot's
// generation; release and check read the slot's generation; fresh or full allocates and bad
// commands read neither memory. The response may wait on rsp_ready when the output register
// is still full. The memories' registered reads are chained, then the write-back follows.
// Slots from the never-used mark up take generation zero unread: no clearing pass after reset.
module generational_handle_slot_table #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_WIDTH  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [1:0]                          command,
    input  logic [hst_pkg::SLOT_FIELD_W-1:0]    slot_index,
    input  logic [hst_pkg::GEN_FIELD_W-1:0]     handle_generation,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [1:0]                          status,
    output logic [hst_pkg::SLOT_FIELD_W-1:0]    result_slot,
    output logic [hst_pkg::GEN_FIELD_W-1:0]     result_generation,
    output logic [hst_pkg::LIVE_FIELD_W-1:0]    live_count
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W  = (CNT_W > hst_pkg::SLOT_FIELD_W) ? CNT_W : hst_pkg::SLOT_FIELD_W;
    localparam int ENT_W  = GEN_WIDTH + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LOOK
    } state_t;

    typedef enum logic [2:0] {
        K_POP,
        K_FRESH,
        K_FULL,
        K_REL,
        K_CHK,
        K_BAD
    } kind_t;

    state_t                           state_reg, state_next;
    kind_t                            kind_reg, kind_next;
    logic [SLOT_W-1:0]                addr_reg, addr_next;
    logic [hst_pkg::SLOT_FIELD_W-1:0] slot_reg, slot_next;
    logic [hst_pkg::GEN_FIELD_W-1:0]  hgen_reg, hgen_next;
    logic [CNT_W-1:0]                 free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]                 ever_used_reg, ever_used_next;
    logic [CNT_W-1:0]                 live_reg, live_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    logic [1:0]                       status_reg, status_next;
    logic [hst_pkg::SLOT_FIELD_W-1:0] rslot_reg, rslot_next;
    logic [hst_pkg::GEN_FIELD_W-1:0]  rgen_reg, rgen_next;
    logic [hst_pkg::LIVE_FIELD_W-1:0] rlive_reg, rlive_next;

    logic              accept;
    logic              done;
    logic              gen_rd_en;
    logic [SLOT_W-1:0] gen_rd_addr;
    logic [ENT_W-1:0]  gen_rd_data;
    logic              gen_wr_en;
    logic [ENT_W-1:0]  gen_wr_data;
    logic              stk_rd_en;
    logic [SLOT_W-1:0] stk_rd_addr;
    logic [SLOT_W-1:0] stk_rd_data;
    logic              stk_wr_en;
    logic [SLOT_W-1:0] stk_wr_addr;
    logic [GEN_WIDTH-1:0] entry_gen;
    logic              entry_used;
    logic              handle_ok;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign done      = (state_reg == S_LOOK) && (!rsp_valid_reg || rsp_ready);

    assign entry_gen  = gen_rd_data[GEN_WIDTH-1:0];
    assign entry_used = gen_rd_data[GEN_WIDTH];

    // handle validity: slot handed out before, in use, same generation
    assign handle_ok = (IDX_W'(slot_reg) < IDX_W'(ever_used_reg)) && entry_used
                       && (entry_gen == GEN_WIDTH'(hgen_reg));

    // sequencer: classify command, chain memory reads, write back and respond
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        hgen_next       = hgen_reg;
        free_depth_next = free_depth_reg;
        ever_used_next  = ever_used_reg;
        live_next       = live_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;
        rslot_next      = rslot_reg;
        rgen_next       = rgen_reg;
        rlive_next      = rlive_reg;
        gen_rd_en       = 1'b0;
        gen_rd_addr     = SLOT_W'(slot_index);
        gen_wr_en       = 1'b0;
        gen_wr_data     = {1'b0, entry_gen};
        stk_rd_en       = 1'b0;
        stk_rd_addr     = SLOT_W'(free_depth_reg - CNT_W'(1));
        stk_wr_en       = 1'b0;
        stk_wr_addr     = SLOT_W'(free_depth_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next  = slot_index;
                    hgen_next  = handle_generation;
                    addr_next  = SLOT_W'(slot_index);
                    state_next = S_LOOK;
                    unique case (command)
                        hst_pkg::CMD_ALLOC:
                        begin
                            if (free_depth_reg != '0)
                            begin
                                kind_next  = K_POP;
                                stk_rd_en  = 1'b1;
                                state_next = S_POP;
                            end
                            else if (ever_used_reg < CNT_W'(SLOT_COUNT))
                            begin
                                kind_next = K_FRESH;
                                addr_next = SLOT_W'(ever_used_reg);
                            end
                            else
                            begin
                                kind_next = K_FULL;
                            end
                        end
                        hst_pkg::CMD_RELEASE:
                        begin
                            kind_next = K_REL;
                            gen_rd_en = 1'b1;
                        end
                        hst_pkg::CMD_CHECK:
                        begin
                            kind_next = K_CHK;
                            gen_rd_en = 1'b1;
                        end
                        default:
                        begin
                            kind_next = K_BAD;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // popped slot is ready, fetch its generation
                addr_next   = stk_rd_data;
                gen_rd_en   = 1'b1;
                gen_rd_addr = stk_rd_data;
                state_next  = S_LOOK;
            end
            S_LOOK:
            begin
                if (done)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rslot_next     = slot_reg;
                    rgen_next      = '0;
                    status_next    = hst_pkg::ST_BAD;
                    case (kind_reg)
                        K_POP:
                        begin
                            status_next     = hst_pkg::ST_OK;
                            rslot_next      = hst_pkg::SLOT_FIELD_W'(addr_reg);
                            rgen_next       = hst_pkg::GEN_FIELD_W'(entry_gen);
                            gen_wr_en       = 1'b1;
                            gen_wr_data     = {1'b1, entry_gen};
                            free_depth_next = free_depth_reg - CNT_W'(1);
                            live_next       = live_reg + CNT_W'(1);
                        end
                        K_FRESH:
                        begin
                            // never-used slot still has generation zero
                            status_next    = hst_pkg::ST_OK;
                            rslot_next     = hst_pkg::SLOT_FIELD_W'(addr_reg);
                            gen_wr_en      = 1'b1;
                            gen_wr_data    = {1'b1, {GEN_WIDTH{1'b0}}};
                            ever_used_next = ever_used_reg + CNT_W'(1);
                            live_next      = live_reg + CNT_W'(1);
                        end
                        K_FULL:
                        begin
                            status_next = hst_pkg::ST_FULL;
                            rslot_next  = '0;
                        end
                        K_REL:
                        begin
                            if (handle_ok)
                            begin
                                status_next = hst_pkg::ST_OK;
                                gen_wr_en   = 1'b1;
                                gen_wr_data = {1'b0, entry_gen + GEN_WIDTH'(1)};
                                if (free_depth_reg < CNT_W'(SLOT_COUNT))
                                begin
                                    stk_wr_en       = 1'b1;
                                    free_depth_next = free_depth_reg + CNT_W'(1);
                                end
                                live_next = live_reg - CNT_W'(1);
                            end
                        end
                        K_CHK:
                        begin
                            if (handle_ok)
                            begin
                                status_next = hst_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            status_next = hst_pkg::ST_BAD;
                        end
                    endcase
                    rlive_next = hst_pkg::LIVE_FIELD_W'(live_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_BAD;
            free_depth_reg <= '0;
            ever_used_reg  <= '0;
            live_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            free_depth_reg <= free_depth_next;
            ever_used_reg  <= ever_used_next;
            live_reg       <= live_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        slot_reg   <= slot_next;
        hgen_reg   <= hgen_next;
        status_reg <= status_next;
        rslot_reg  <= rslot_next;
        rgen_reg   <= rgen_next;
        rlive_reg  <= rlive_next;
    end

    hst_gen_store #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W),
        .DATA_W (ENT_W)
    ) u_gen_store (
        .clk     (clk),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data),
        .wr_en   (gen_wr_en),
        .wr_addr (addr_reg),
        .wr_data (gen_wr_data)
    );

    hst_free_stack #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_free_stack (
        .clk     (clk),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (addr_reg)
    );

    assign rsp_valid         = rsp_valid_reg;
    assign status            = status_reg;
    assign result_slot       = rslot_reg;
    assign result_generation = rgen_reg;
    assign live_count        = rlive_reg;

    // every slot ever handed out is either live or on the free stack
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(free_depth_reg) + (CNT_W + 1)'(live_reg) == (CNT_W + 1)'(ever_used_reg))
        else $error("free stack depth and live count do not add up to slots handed out");

    // a pop is only started with a non-empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (free_depth_reg != '0))
        else $error("pop from empty free stack");

    // a fresh grant stays within the table
    a_fresh_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && kind_reg == K_FRESH) |-> (ever_used_reg < CNT_W'(SLOT_COUNT)))
        else $error("fresh slot beyond table size");

    // a finished command always produces a response
    a_done_responds: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid_reg)
        else $error("finished command without response");

endmodule
